// ----- rtl/core/shs_pkg.sv -----
`default_nettype none

package shs_pkg;

    localparam int SHS_WORDS = 8;
    localparam int SHS_WIN   = 16;

    localparam logic       SHS_CMD_ABSORB = 1'b0;
    localparam logic       SHS_CMD_FINISH = 1'b1;
    localparam logic [7:0] SHS_MARK       = 8'h80;
    localparam logic [5:0] SHS_LAST_POS   = 6'd63;
    localparam logic [5:0] SHS_LEN_POS    = 6'd56;
    localparam logic [5:0] SHS_LAST_RND   = 6'd63;
    localparam logic [2:0] SHS_LAST_WORD  = 3'd7;

    localparam logic [31:0] SHS_IV [SHS_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHS_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // sequencer -> schedule/round unit
    typedef struct packed {
        logic       shift;
        logic [7:0] data;
        logic       start;
        logic       reinit;
    } t_shs_ctl;

    // round unit -> sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_shs_sts;

    function automatic logic [31:0] shs_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] shs_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] shs_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] shs_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shs_in_if.sv -----
`default_nettype none

interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/shs_out_if.sv -----
`default_nettype none

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/shs_sched.sv -----
`default_nettype none

// Block buffer and message schedule in one 16-word window.
// Bytes shift in at the tail; during rounds the window advances one word
// per cycle and the head is W[t].
module shs_sched
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_shs_ctl    i_ctl,
    input  wire logic        i_step,
    output logic [31:0]      o_w
);

    logic [31:0] r_win [SHS_WIN];
    logic [31:0] w_next;

    assign w_next = r_win[0] + shs_ssig0(r_win[1]) + r_win[9] + shs_ssig1(r_win[14]);
    assign o_w    = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < SHS_WIN - 1; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[SHS_WIN-1] <= {r_win[SHS_WIN-1][23:0], i_ctl.data};
        end else if (i_step) begin
            for (int i = 0; i < SHS_WIN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[SHS_WIN-1] <= w_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/shs_round.sv -----
`default_nettype none

// One SHA-256 round per cycle over the working words, then a fold cycle
// that adds them into the chaining words.
module shs_round
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_shs_ctl    i_ctl,
    input  wire logic [31:0] i_w,
    output t_shs_sts         o_sts,
    output logic [31:0]      o_chain [SHS_WORDS]
);

    logic [31:0] r_h [SHS_WORDS];
    logic [31:0] r_s [SHS_WORDS];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_fold;

    logic [31:0] w_ch, w_mj, w_t1, w_t2;

    always_comb begin
        w_ch = (r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]);
        w_mj = (r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]);
        w_t1 = r_s[7] + shs_bsig1(r_s[4]) + w_ch + SHS_K[r_rnd] + i_w;
        w_t2 = shs_bsig0(r_s[0]) + w_mj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_rnd  <= '0;
            r_h    <= SHS_IV;
        end else begin
            r_fold <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == SHS_LAST_RND) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end
            if (i_ctl.reinit) begin
                r_h <= SHS_IV;
            end else if (r_fold) begin
                for (int i = 0; i < SHS_WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_s[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_s <= r_h;
        end else if (r_busy) begin
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + w_t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= w_t1 + w_t2;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_fold;
    assign o_chain    = r_h;

endmodule

`default_nettype wire

// ----- rtl/core/sha256_stream_hash.sv -----
// Absorb byte: the 64th byte of a block also starts a compression that holds off
// the next byte until its 64 rounds and the fold are done.
// Finish command: padding then shifts in one byte per cycle (64 - fill bytes, or that
// plus 64 when no room for the length), a compression per block, then 8 digest words.
// Rate is set by the single shared round unit. Synchronous active-low reset
// restores the initial hash values and clears fill and length counts.
`default_nettype none

module sha256_stream_hash
    import shs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    shs_in_if.sink     i_in,
    shs_out_if.source  o_out
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HASH  = 5'b00010,
        ST_PAD   = 5'b00100,
        ST_PHASH = 5'b01000,
        ST_OUT   = 5'b10000
    } t_shs_state;

    t_shs_state  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_msg, n_msg;
    logic        r_mark, n_mark;
    logic        r_len_blk, n_len_blk;
    logic [2:0]  r_idx, n_idx;

    t_shs_ctl    ctl;
    t_shs_sts    sts;
    logic [31:0] w_sched;
    logic [31:0] w_chain [SHS_WORDS];
    logic [63:0] w_bits;
    logic [7:0]  w_len_byte;
    logic        w_in_acc, w_out_acc;

    assign w_bits     = {r_msg, 3'b000};
    // length byte at buffer position 56+k is bit-length byte 7-k
    assign w_len_byte = w_bits[{~r_fill[2:0], 3'b000} +: 8];

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_msg     = r_msg;
        n_mark    = r_mark;
        n_len_blk = r_len_blk;
        n_idx     = r_idx;
        ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.cmd == SHS_CMD_FINISH) begin
                        n_state = ST_PAD;
                        n_mark  = 1'b1;
                    end else begin
                        ctl.shift = 1'b1;
                        ctl.data  = i_in.data_byte;
                        n_fill    = r_fill + 6'd1;
                        n_msg     = r_msg + 61'd1;
                        if (r_fill == SHS_LAST_POS) begin
                            ctl.start = 1'b1;
                            n_state   = ST_HASH;
                        end
                    end
                end
            end
            ST_HASH: begin
                if (sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                ctl.shift = 1'b1;
                n_fill    = r_fill + 6'd1;
                if (r_mark) begin
                    ctl.data  = SHS_MARK;
                    n_mark    = 1'b0;
                    // length fits in this block only if the marker lands before it
                    n_len_blk = (r_fill < SHS_LEN_POS);
                end else if (r_len_blk && (r_fill >= SHS_LEN_POS)) begin
                    ctl.data = w_len_byte;
                end else begin
                    ctl.data = 8'h00;
                end
                if (r_fill == SHS_LAST_POS) begin
                    ctl.start = 1'b1;
                    n_state   = ST_PHASH;
                end
            end
            ST_PHASH: begin
                if (sts.done) begin
                    if (r_len_blk) begin
                        n_state = ST_OUT;
                        n_idx   = '0;
                    end else begin
                        n_len_blk = 1'b1;
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_OUT: begin
                if (w_out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == SHS_LAST_WORD) begin
                        ctl.reinit = 1'b1;
                        n_msg      = '0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_msg     <= '0;
            r_mark    <= 1'b0;
            r_len_blk <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_msg     <= n_msg;
            r_mark    <= n_mark;
            r_len_blk <= n_len_blk;
            r_idx     <= n_idx;
        end
    end

    shs_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_step (sts.busy),
        .o_w    (w_sched)
    );

    shs_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w     (w_sched),
        .o_sts   (sts),
        .o_chain (w_chain)
    );

    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = w_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == SHS_LAST_WORD);

    a_out_idle_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !sts.busy && !sts.done)
        else $error("digest word shown while compression active");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.start |-> !sts.busy && r_fill == SHS_LAST_POS)
        else $error("compression started while busy or block not full");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.done |-> $past(sts.busy))
        else $error("fold without preceding rounds");

    a_clear_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_word) |=> (r_fill == 6'd0 && r_msg == 61'd0))
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire
